@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the nearest-node and steer unit.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ rtl/core/rrtns_pkg.sv @@
// Shared types and constants for the nearest-node and steer unit.
// Depends on nothing.
package rrtns_pkg;
  localparam int MAX_NODES = 1024;
  localparam int NODE_AW = 10;
  localparam logic [1:0] CMD_ROOT = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;
  localparam logic [1:0] CMD_EXTEND = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BADPARENT = 2'd3;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [14:0] STEP_RESET = 15'd26;
  localparam int REG_STEP = 0;

  typedef struct packed {
    logic [1:0] command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [9:0] parent_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] nearest_index;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [10:0] node_count;
  } out_item_t;
endpackage

@@ rtl/core/rrtns_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
module rrtns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/core/rrtns_cordic.sv @@
// Iterative CORDIC steer: vectoring pass then rotation pass, one step a cycle.
// Depends on rrtns_pkg.
module rrtns_cordic (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dy,
  input  logic [14:0] step_length,
  output logic        done,
  output logic signed [16:0] off_x,
  output logic signed [16:0] off_y
);
  import rrtns_pkg::*;
  localparam int STEPS = 16;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_VEC = 2'd1;
  localparam logic [1:0] S_ROT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [3:0] iter;
  logic [STEPS-1:0] cw;
  logic flip;
  logic zero_vec;
  logic signed [34:0] x, y;
  logic signed [34:0] rx, ry, rnx, rny;

  assign zero_vec = (dx == 17'sd0) && (dy == 17'sd0);
  assign rx = x + 35'sd32768;
  assign ry = y + 35'sd32768;
  assign rnx = flip ? -(rx >>> 16) : (rx >>> 16);
  assign rny = flip ? -(ry >>> 16) : (ry >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE) || (state == S_IDLE && start && zero_vec);
      case (state)
        S_IDLE: begin
          if (start) begin
            iter <= '0;
            if (zero_vec) begin
              off_x <= {2'b00, step_length};
              off_y <= '0;
            end else begin
              flip <= dx[16];
              x <= dx[16] ? -35'(dx) : 35'(dx);
              y <= dx[16] ? -35'(dy) : 35'(dy);
              state <= S_VEC;
            end
          end
        end
        S_VEC: begin
          cw[iter] <= ~y[34];
          iter <= iter + 4'd1;
          if (iter == 4'(STEPS - 1)) begin
            // seed the rotation with step_length / K
            x <= 35'($unsigned(step_length) * $unsigned(INV_GAIN_Q16));
            y <= '0;
            state <= S_ROT;
          end else if (!y[34]) begin
            x <= x + (y >>> iter);
            y <= y - (x >>> iter);
          end else begin
            x <= x - (y >>> iter);
            y <= y + (x >>> iter);
          end
        end
        S_ROT: begin
          if (cw[iter]) begin
            x <= x - (y >>> iter);
            y <= y + (x >>> iter);
          end else begin
            x <= x + (y >>> iter);
            y <= y - (x >>> iter);
          end
          iter <= iter + 4'd1;
          if (iter == 4'(STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          off_x <= rnx[16:0];
          off_y <= rny[16:0];
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

@@ rtl/core/rrt_nearest_node_and_steer_unit.sv @@
// Nearest-node search and steer unit; depends on rrtns_pkg, rrtns_ram, rrtns_cordic, assert_macros.svh.
// Set root, add child, empty extend and unknown commands answer straight from idle with a
// registered result; extend scans every node, fetches the nearest, runs the CORDIC steer
// and then outputs, and the CORDIC skips its passes when the target sits on the nearest node.
// One item at a time; the next beat can be taken in the cycle after the result beat is accepted.
// Reset clears the node count and sets step length to 26; node memories keep contents.
`include "assert_macros.svh"
module rrt_nearest_node_and_steer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrtns_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrtns_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rrtns_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_STEER = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state;
  logic [14:0] step_length;
  logic [10:0] count, count_next;
  in_item_t item;
  out_item_t imm;
  logic take, add_ok;
  logic [10:0] rd_idx;
  logic rd_vld;
  logic [NODE_AW-1:0] rd_tag, best;
  logic [33:0] best_d;
  logic have_best;
  logic we;
  logic [NODE_AW-1:0] addr;
  logic signed [15:0] wx, wy, qx, qy;
  logic [9:0] wp, qp;
  logic signed [16:0] ddx, ddy;
  logic signed [33:0] sqx, sqy;
  logic [33:0] sq_dist;
  logic cstart, cdone;
  logic signed [16:0] ox, oy;
  logic signed [17:0] sx, sy;
  logic signed [15:0] nbx, nby;

  assign pready = 1'b1;
  assign prdata = {17'd0, step_length};
  assign in_stall = (state != S_IDLE) || out_valid;
  assign take = in_valid && !in_stall;

  // Result and new count for every command that answers at once.
  always_comb begin
    imm = '0;
    count_next = count;
    add_ok = 1'b0;
    case (in_data.command)
      CMD_ROOT: begin
        count_next = 11'd1;
      end
      CMD_ADD: begin
        if (count == 11'd0) imm.status = ST_EMPTY;
        else if (count >= 11'(MAX_NODES)) imm.status = ST_FULL;
        else if ({1'b0, in_data.parent_index} >= count) imm.status = ST_BADPARENT;
        else begin
          add_ok = 1'b1;
          count_next = count + 11'd1;
        end
      end
      CMD_EXTEND: begin
        if (count == 11'd0) imm.status = ST_EMPTY;
      end
      default: ;
    endcase
    imm.node_count = count_next;
  end

  always_comb begin
    we = 1'b0;
    addr = rd_idx[NODE_AW-1:0];
    wx = in_data.pos_x;
    wy = in_data.pos_y;
    wp = in_data.parent_index;
    if (take) begin
      if (in_data.command == CMD_ROOT) begin
        we = 1'b1;
        addr = '0;
        wp = '0;
      end else if (add_ok) begin
        we = 1'b1;
        addr = count[NODE_AW-1:0];
      end
    end else if (state != S_IDLE && state != S_SCAN) begin
      // hold the nearest node on the read port through fetch, steer and output
      addr = best;
    end
  end

  rrtns_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_xram
    (.clk(clk), .we(we), .addr(addr), .wdata(wx), .rdata(qx));
  rrtns_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_yram
    (.clk(clk), .we(we), .addr(addr), .wdata(wy), .rdata(qy));
  rrtns_ram #(.WIDTH(10), .DEPTH(MAX_NODES)) u_pram
    (.clk(clk), .we(we), .addr(addr), .wdata(wp), .rdata(qp));

  assign ddx = 17'(item.pos_x) - 17'(qx);
  assign ddy = 17'(item.pos_y) - 17'(qy);
  assign sqx = 34'(ddx) * 34'(ddx);
  assign sqy = 34'(ddy) * 34'(ddy);
  assign sq_dist = $unsigned(sqx) + $unsigned(sqy);

  rrtns_cordic u_cordic (.clk(clk), .rst(rst), .start(cstart), .dx(ddx), .dy(ddy),
    .step_length(step_length), .done(cdone), .off_x(ox), .off_y(oy));

  assign sx = 18'(qx) + 18'(ox);
  assign sy = 18'(qy) + 18'(oy);
  assign nbx = (sx > 18'sd32767) ? 16'sh7fff : (sx < -18'sd32768) ? 16'sh8000 : sx[15:0];
  assign nby = (sy > 18'sd32767) ? 16'sh7fff : (sy < -18'sd32768) ? 16'sh8000 : sy[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step_length <= STEP_RESET;
      out_valid <= 1'b0;
      rd_vld <= 1'b0;
      cstart <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'(REG_STEP)) begin
        step_length <= pwdata[14:0];
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            item <= in_data;
            if (in_data.command == CMD_EXTEND && count != 11'd0) begin
              rd_idx <= '0;
              rd_vld <= 1'b0;
              have_best <= 1'b0;
              state <= S_SCAN;
            end else begin
              count <= count_next;
              out_data <= imm;
              out_valid <= 1'b1;
            end
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          // advance the read address while the previous entry's data compares
          rd_vld <= (rd_idx < count);
          rd_tag <= rd_idx[NODE_AW-1:0];
          if (rd_idx < count) rd_idx <= rd_idx + 11'd1;
          if (rd_vld && (!have_best || sq_dist < best_d)) begin
            best_d <= sq_dist;
            best <= rd_tag;
            have_best <= 1'b1;
          end
          if (rd_vld == 1'b0 && rd_idx == count && have_best) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          cstart <= 1'b1;
          state <= S_STEER;
        end
        S_STEER: begin
          cstart <= 1'b0;
          if (cdone) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_data.status <= ST_OK;
          out_data.nearest_index <= best;
          out_data.new_x <= nbx;
          out_data.new_y <= nby;
          out_data.node_count <= count;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_busy_stalls, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_IMPLY(a_count_max, clk, rst, 1'b1, count <= 11'(MAX_NODES))
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

@@ tb/rrt_nearest_node_and_steer_unit_tb.sv @@
// Testbench for the nearest-node and steer unit: random and directed command beats
// checked against a behavioral predictor of the node table and CORDIC steer.
// Depends on rrtns_pkg and rrt_nearest_node_and_steer_unit.
`timescale 1ns / 100ps

module rrt_nearest_node_and_steer_unit_tb;
  import rrtns_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int TURNS = 16;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  class steer_scoreboard;
    logic signed [15:0] node_x [TABLE_DEPTH];
    logic signed [15:0] node_y [TABLE_DEPTH];
    int node_total;
    logic [14:0] step_len;
    out_item_t pending [$];
    int errors;

    function void clear();
      node_total = 0;
      step_len = STEP_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function longint shr(longint v, int s);
      return v >>> s;
    endfunction

    function void steer_offset(longint dx, longint dy, output longint ox, output longint oy);
      bit flip;
      bit cw [TURNS];
      longint x, y, t;
      flip = 0;
      if (dx == 0 && dy == 0) begin
        ox = longint'(step_len);
        oy = 0;
        return;
      end
      x = dx;
      y = dy;
      if (x < 0) begin
        x = -x;
        y = -y;
        flip = 1;
      end
      for (int i = 0; i < TURNS; i++) begin
        cw[i] = (y >= 0);
        if (cw[i]) begin
          t = x + shr(y, i);
          y = y - shr(x, i);
        end else begin
          t = x - shr(y, i);
          y = y + shr(x, i);
        end
        x = t;
      end
      x = longint'(step_len) * longint'(INV_GAIN_Q16);
      y = 0;
      for (int i = 0; i < TURNS; i++) begin
        if (cw[i]) begin
          t = x - shr(y, i);
          y = y + shr(x, i);
        end else begin
          t = x + shr(y, i);
          y = y - shr(x, i);
        end
        x = t;
      end
      x = shr(x + 32768, 16);
      y = shr(y + 32768, 16);
      ox = flip ? -x : x;
      oy = flip ? -y : y;
    endfunction

    function logic signed [15:0] clamp(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function void note_command(in_item_t it);
      out_item_t r;
      longint px, py, d, best_d, ox, oy;
      int best;
      r = '0;
      px = it.pos_x;
      py = it.pos_y;
      case (it.command)
        CMD_ROOT: begin
          node_x[0] = it.pos_x;
          node_y[0] = it.pos_y;
          node_total = 1;
        end
        CMD_ADD: begin
          if (node_total == 0) r.status = ST_EMPTY;
          else if (node_total >= TABLE_DEPTH) r.status = ST_FULL;
          else if (it.parent_index >= node_total) r.status = ST_BADPARENT;
          else begin
            node_x[node_total] = it.pos_x;
            node_y[node_total] = it.pos_y;
            node_total++;
          end
        end
        CMD_EXTEND: begin
          if (node_total == 0) r.status = ST_EMPTY;
          else begin
            best = 0;
            best_d = 0;
            for (int i = 0; i < node_total; i++) begin
              d = (px - node_x[i]) * (px - node_x[i]) + (py - node_y[i]) * (py - node_y[i]);
              if (i == 0 || d < best_d) begin
                best_d = d;
                best = i;
              end
            end
            steer_offset(px - node_x[best], py - node_y[best], ox, oy);
            r.nearest_index = 10'(best);
            r.new_x = clamp(longint'(node_x[best]) + ox);
            r.new_y = clamp(longint'(node_y[best]) + oy);
          end
        end
        default: ;
      endcase
      r.node_count = 11'(node_total);
      pending = {pending, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) begin
        $error("status expected %0d actual %0d", w.status, got.status); errors++;
      end
      if (got.nearest_index !== w.nearest_index) begin
        $error("nearest_index expected %0d actual %0d", w.nearest_index, got.nearest_index);
        errors++;
      end
      if (got.new_x !== w.new_x) begin
        $error("new_x expected %0d actual %0d", w.new_x, got.new_x); errors++;
      end
      if (got.new_y !== w.new_y) begin
        $error("new_y expected %0d actual %0d", w.new_y, got.new_y); errors++;
      end
      if (got.node_count !== w.node_count) begin
        $error("node_count expected %0d actual %0d", w.node_count, got.node_count); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  steer_scoreboard board;
  bit calm;
  longint cycles;

  rrt_nearest_node_and_steer_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    board = new();
    board.clear();
  end

  // Receiver: stall in bursts, check each accepted beat.
  initial begin
    int burst;
    out_stall = 0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_result(out_data);
      if (burst > 0) burst--;
      else if (!calm && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 14);
      out_stall <= (burst > 0);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("rrt_nearest_node_and_steer_unit_tb failed");
        $finish;
      end
    end
  end

  task automatic write_step(logic [14:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 2'(REG_STEP * 4);
    pwdata <= {17'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.step_len = v;
  endtask

  // Valid stays up after the beat is taken until a random gap in a later call, drain() or the test sequence drops it.
  task automatic send(in_item_t it, bit gaps);
    if (gaps && !calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    board.note_command(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  function automatic in_item_t make(logic [1:0] c, int x, int y, int p);
    in_item_t it;
    it.command = c;
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    it.parent_index = 10'(p);
    return it;
  endfunction

  function automatic int near_coord(int c);
    int v;
    v = c + $signed($urandom_range(0, 2047)) - 1024;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin
    in_item_t it;
    int r, idx;
    logic [14:0] steps [5];
    rst = 1;
    calm = 0;
    in_valid = 0;
    in_data = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty-tree cases, extremes, ties, coincident target.
    send(make(CMD_ADD, 5, 5, 0), 0);
    send(make(CMD_EXTEND, 0, 0, 0), 0);
    send(make(CMD_IGNORED, -1, -1, 1023), 0);
    send(make(CMD_ROOT, -32768, 32767, 1023), 0);
    send(make(CMD_EXTEND, -32768, 32767, 0), 0);
    send(make(CMD_EXTEND, 32767, -32768, 0), 0);
    send(make(CMD_ADD, 32767, -32768, 1), 0);
    send(make(CMD_ADD, 32767, -32768, 0), 0);
    send(make(CMD_ADD, 0, 0, 1), 0);
    send(make(CMD_ADD, 0, 0, 1023), 0);
    send(make(CMD_EXTEND, 0, 0, 0), 0);
    send(make(CMD_ROOT, 100, 0, 0), 0);
    send(make(CMD_ADD, -100, 0, 0), 0);
    send(make(CMD_EXTEND, 0, 0, 0), 0);
    send(make(CMD_EXTEND, 0, 50, 0), 0);
    send(make(CMD_EXTEND, 0, -50, 0), 0);
    send(make(CMD_EXTEND, -200, -7, 0), 0);
    send(make(CMD_EXTEND, 32767, 32767, 0), 0);
    drain();
    write_step(15'h7fff);
    send(make(CMD_EXTEND, 32767, 32767, 0), 0);
    send(make(CMD_EXTEND, -32768, -32768, 0), 0);
    send(make(CMD_EXTEND, 100, 0, 0), 0);
    drain();
    write_step(15'd0);
    send(make(CMD_EXTEND, 300, -300, 0), 0);
    drain();

    // Random phases with different step lengths; trees kept small.
    steps[0] = STEP_RESET;
    steps[1] = 15'd1;
    steps[2] = 15'($urandom_range(2, 32766));
    steps[3] = 15'h7fff;
    steps[4] = 15'($urandom_range(0, 600));
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_step(steps[ph]);
      if (ph == 4) calm = 1;
      for (int n = 0; n < 85; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5 || board.node_total == 0)
          send(make(CMD_ROOT, $urandom, $urandom, $urandom), 1);
        else if (r < 8)
          send(make(CMD_IGNORED, $urandom, $urandom, $urandom), 1);
        else if (r < 13)
          send(make(CMD_ADD, $urandom, $urandom,
                    $urandom_range(board.node_total, 1023)), 1);
        else if (r < 45 && board.node_total < 40)
          send(make(CMD_ADD, $urandom, $urandom,
                    $urandom_range(0, board.node_total - 1)), 1);
        else begin
          idx = $urandom_range(0, board.node_total - 1);
          if ($urandom_range(0, 3) == 0)
            it = make(CMD_EXTEND, board.node_x[idx], board.node_y[idx], $urandom);
          else if ($urandom_range(0, 1) == 0)
            it = make(CMD_EXTEND, near_coord(board.node_x[idx]),
                      near_coord(board.node_y[idx]), $urandom);
          else
            it = make(CMD_EXTEND, $urandom, $urandom, $urandom);
          send(it, 1);
        end
        if (ph == 1 && n == 45) begin
          in_valid <= 0;
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    if (board.errors == 0) $display("rrt_nearest_node_and_steer_unit_tb passed");
    else $display("rrt_nearest_node_and_steer_unit_tb failed");
    $finish;
  end
endmodule
